// ===== rtl/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 package
// Shared constants, S-box and round functions for the SM4 block cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned RK_IDX_W   = 5;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Four 32-bit words carried between cells
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_block;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] x);
        subst = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] t_data(input logic [31:0] x);
        logic [31:0] b;
        b = subst(x);
        t_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] t_key(input logic [31:0] x);
        logic [31:0] b;
        b = subst(x);
        t_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK byte j of word i is (4*i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
        logic [7:0] base;
        base = {1'b0, i, 2'b00};
        ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                   8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
    endfunction

endpackage

// ===== rtl/sm4_block_cipher.sv =====
// Path from accepted start to o_done: 32 round cells, then the output reg.
// One block per cycle while busy is low; the round cells form a 32-deep pipeline.
// After a key write the schedule unit expands the round keys; busy is high then.
// Reset (i_rst_n low, synchronous) clears keys, mode and the pipeline valids.
// Results are shown for one cycle on o_done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// SM4 block cipher top
// APB key/mode registers, key schedule and a chain of 32 round cells.
// ----------------------------------------------------------------------------
module sm4_block_cipher import sm4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_text_word0,
    input  logic [31:0] i_text_word1,
    input  logic [31:0] i_text_word2,
    input  logic [31:0] i_text_word3,
    output logic        o_done,
    output logic [31:0] o_result_word0,
    output logic [31:0] o_result_word1,
    output logic [31:0] o_result_word2,
    output logic [31:0] o_result_word3
);

    t_block      r_key;
    logic        r_mode;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        key_busy;
    logic [31:0] rk [NUM_ROUNDS];
    logic        vld [NUM_ROUNDS+1];
    t_block      blk [NUM_ROUNDS+1];
    logic        r_done;
    t_block      r_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= 1'b0;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            case (reg_idx)
                REG_KEY0: r_key.w0 <= pwdata;
                REG_KEY1: r_key.w1 <= pwdata;
                REG_KEY2: r_key.w2 <= pwdata;
                REG_KEY3: r_key.w3 <= pwdata;
                REG_MODE: r_mode   <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY0: prdata = r_key.w0;
            REG_KEY1: prdata = r_key.w1;
            REG_KEY2: prdata = r_key.w2;
            REG_KEY3: prdata = r_key.w3;
            REG_MODE: prdata = {31'd0, r_mode};
            default:  prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00) prdata = '0;
    end

    t_block key_nxt;
    logic   key_wr;
    always_comb begin
        key_nxt = r_key;
        key_wr  = wr_en && paddr[1:0] == 2'b00 && reg_idx <= REG_KEY3;
        case (reg_idx)
            REG_KEY0: key_nxt.w0 = pwdata;
            REG_KEY1: key_nxt.w1 = pwdata;
            REG_KEY2: key_nxt.w2 = pwdata;
            REG_KEY3: key_nxt.w3 = pwdata;
            default:  ;
        endcase
    end

    sm4_key_sched u_ksched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_wr),
        .i_key   (key_nxt),
        .o_busy  (key_busy),
        .o_rk    (rk)
    );

    assign busy   = key_busy;
    assign vld[0] = start && !key_busy;
    assign blk[0] = '{i_text_word0, i_text_word1, i_text_word2, i_text_word3};

    // chain of round cells
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        sm4_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[g]),
            .i_blk   (blk[g]),
            .i_rk    (r_mode ? rk[NUM_ROUNDS-1-g] : rk[g]),
            .o_vld   (vld[g+1]),
            .o_blk   (blk[g+1])
        );
    end

    // output register, words reversed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= vld[NUM_ROUNDS];
        end
        r_res <= '{blk[NUM_ROUNDS].w3, blk[NUM_ROUNDS].w2, blk[NUM_ROUNDS].w1,
                   blk[NUM_ROUNDS].w0};
    end

    assign o_done         = r_done;
    assign o_result_word0 = r_res.w0;
    assign o_result_word1 = r_res.w1;
    assign o_result_word2 = r_res.w2;
    assign o_result_word3 = r_res.w3;

`ifndef SYNTHESIS
    // no request accepted while keys are expanding
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_busy |-> !vld[0]) else $error("accept during key expansion");
    // a request reaches the output after the full pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[0] |-> ##(NUM_ROUNDS+1) o_done) else $error("lost request");
    // key write starts expansion
    a_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_wr |=> key_busy) else $error("expansion not started");
`endif

endmodule

// ===== rtl/sm4_round_cell.sv =====
// ----------------------------------------------------------------------------
// SM4 round cell
// One cipher round: registers the shifted block and passes it on each cycle.
// ----------------------------------------------------------------------------
module sm4_round_cell import sm4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_block      i_blk,
    input  logic [31:0] i_rk,
    output logic        o_vld,
    output t_block      o_blk
);

    logic   r_vld;
    t_block r_blk;
    t_block n_blk;

    // X4 = X0 ^ T(X1^X2^X3^rk), then shift the window
    always_comb begin
        n_blk.w0 = i_blk.w1;
        n_blk.w1 = i_blk.w2;
        n_blk.w2 = i_blk.w3;
        n_blk.w3 = i_blk.w0 ^ t_data(i_blk.w1 ^ i_blk.w2 ^ i_blk.w3 ^ i_rk);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_blk <= n_blk;
    end

    assign o_vld = r_vld;
    assign o_blk = r_blk;

endmodule

// ===== rtl/sm4_key_sched.sv =====
// ----------------------------------------------------------------------------
// SM4 key schedule
// Expands the round keys one per cycle after any key write.
// ----------------------------------------------------------------------------
module sm4_key_sched import sm4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_block      i_key,
    output logic        o_busy,
    output logic [31:0] o_rk [NUM_ROUNDS]
);

    logic                r_run;
    logic [RK_IDX_W-1:0] r_idx;
    t_block              r_k;
    logic [31:0]         r_rk [NUM_ROUNDS];
    logic [31:0]         n_key;

    assign n_key = r_k.w0 ^ t_key(r_k.w1 ^ r_k.w2 ^ r_k.w3 ^ ck_word(r_idx));

    // one round key per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_idx <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_idx <= '0;
        end else if (r_run) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == RK_IDX_W'(NUM_ROUNDS - 1)) begin
                r_run <= 1'b0;
            end
        end
        if (i_start) begin
            r_k <= '{i_key.w0 ^ FK0, i_key.w1 ^ FK1, i_key.w2 ^ FK2, i_key.w3 ^ FK3};
        end else if (r_run) begin
            r_k           <= '{r_k.w1, r_k.w2, r_k.w3, n_key};
            r_rk[r_idx]   <= n_key;
        end
    end

    assign o_busy = r_run;
    assign o_rk   = r_rk;

endmodule
